FILE: hdl/euler_state_space_plant_step_top_assert.svh
// assertion macros shared by the checker of the plant step block
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef EULER_STATE_SPACE_PLANT_STEP_TOP_ASSERT_SVH
`define EULER_STATE_SPACE_PLANT_STEP_TOP_ASSERT_SVH

// checked outside reset
`define ESPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ESPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/esps_pkg.sv
// shared types and constants of the plant step block
// used by esps_mac, esps_seq and the top level; no dependencies
package esps_pkg;

  localparam int ORDER    = 3;
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int DT_W     = 31;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int NUM_N    = 4;
  localparam int DEN_N    = 3;
  localparam int CIDX_W   = $clog2(NUM_N);
  localparam int IDX_W    = $clog2(ORDER + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEN1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEN3 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NUM0 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_NUM3 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_DT   = CFG_IDX_W'(7);

  localparam logic [DT_W-1:0] DT_RESET = DT_W'(6554);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // multiplier operand a
  typedef enum logic [1:0] {A_ZERO, A_DEN, A_GAIN, A_DERIV} a_sel_t;
  // multiplier operand b
  typedef enum logic [1:0] {B_U, B_DT, B_STATE, B_GAIN} b_sel_t;
  // addend
  typedef enum logic [1:0] {C_ZERO, C_FWD, C_STATE, C_NUM} c_sel_t;
  // write-back target
  typedef enum logic [1:0] {D_DERIV, D_STATE, D_GAIN, D_OUT} dst_sel_t;

  typedef struct packed {
    logic             step;
    dst_sel_t         dst;
    logic [IDX_W-1:0] d_idx;
  } wb_t;

  typedef struct packed {
    logic             valid;
    a_sel_t           a_sel;
    logic [IDX_W-1:0] a_idx;
    b_sel_t           b_sel;
    logic [IDX_W-1:0] b_idx;
    c_sel_t           c_sel;
    logic [IDX_W-1:0] c_idx;
    logic             sub;
    wb_t              wb;
  } op_t;

  typedef struct packed {
    logic ready;
    logic load_out;
  } seq_ctl_t;

endpackage

FILE: hdl/esps_mac.sv
// shared multiply / saturate / accumulate unit, two stages
// uses esps_pkg
module esps_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 flush,
  input  logic                                 issue,
  input  logic signed [esps_pkg::DATA_W-1:0]   mul_a,
  input  logic signed [esps_pkg::DATA_W-1:0]   mul_b,
  input  logic signed [esps_pkg::DATA_W-1:0]   addend,
  input  logic                                 addend_fwd,
  input  logic                                 sub,
  input  esps_pkg::wb_t                        tag_in,
  output logic                                 res_valid,
  output logic signed [esps_pkg::DATA_W-1:0]   res,
  output logic                                 res_sat,
  output esps_pkg::wb_t                        res_tag
);
  import esps_pkg::*;

  localparam int Q_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] addend_r;
  logic                     sub_r;
  logic                     valid_r;
  wb_t                      tag_r;

  logic signed [Q_W-1:0]    q;
  logic                     q_sat;
  logic signed [DATA_W-1:0] q_clip;
  logic signed [DATA_W:0]   sum;
  logic                     sum_sat;

  // arithmetic shift is floor division by 2^16
  always_comb begin
    q       = prod_r[PROD_W-1:FRAC_W];
    q_sat   = !((&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]));
    q_clip  = q_sat ? (q[Q_W-1] ? SAT_MIN : SAT_MAX) : q[DATA_W-1:0];
    if (sub_r) begin
      sum = {addend_r[DATA_W-1], addend_r} - {q_clip[DATA_W-1], q_clip};
    end else begin
      sum = {addend_r[DATA_W-1], addend_r} + {q_clip[DATA_W-1], q_clip};
    end
    sum_sat = sum[DATA_W] != sum[DATA_W-1];
    res     = sum_sat ? (sum[DATA_W] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];
    res_sat = q_sat | sum_sat;
  end

  assign res_valid = valid_r;
  assign res_tag   = tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= issue;
    end
  end

  // accumulate chains pick up the result still in the second stage
  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(mul_a) * PROD_W'(mul_b);
    addend_r <= addend_fwd ? res : addend;
    sub_r    <= sub;
    tag_r    <= tag_in;
  end

endmodule

FILE: hdl/esps_seq.sv
// micro-op sequencer for the plant step and the gain derivation
// uses esps_pkg
module esps_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_free,
  input  logic               derive_req,
  output esps_pkg::op_t      op,
  output esps_pkg::seq_ctl_t ctl
);
  import esps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_LAST, S_LASTU, S_GAPU, S_UPD, S_OUT, S_DRAIN, S_FIN,
    S_GROW, S_GGAP
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] gi_r, gi_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    gi_nxt       = gi_r;
    op           = '0;
    ctl.ready    = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          state_nxt = (ORDER > 1) ? S_ROW : S_LAST;
          cnt_nxt   = '0;
        end
      end
      // d[r] = x[r+1] + g[r+1]*u
      S_ROW: begin
        op.valid     = 1'b1;
        op.a_sel     = A_GAIN;
        op.a_idx     = cnt_r + IDX_W'(1);
        op.b_sel     = B_U;
        op.c_sel     = C_STATE;
        op.c_idx     = cnt_r + IDX_W'(1);
        op.wb.step   = 1'b1;
        op.wb.dst    = D_DERIV;
        op.wb.d_idx  = cnt_r;
        if (cnt_r == IDX_W'(ORDER - 2)) begin
          state_nxt = S_LAST;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      // last row: acc -= a[ORDER-i]*x[i]
      S_LAST: begin
        op.valid     = 1'b1;
        op.a_sel     = A_DEN;
        op.a_idx     = IDX_W'(ORDER - 1) - cnt_r;
        op.b_sel     = B_STATE;
        op.b_idx     = cnt_r;
        op.c_sel     = (cnt_r == '0) ? C_ZERO : C_FWD;
        op.sub       = 1'b1;
        op.wb.step   = 1'b1;
        op.wb.dst    = D_DERIV;
        op.wb.d_idx  = IDX_W'(ORDER - 1);
        if (cnt_r == IDX_W'(ORDER - 1)) begin
          state_nxt = S_LASTU;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_LASTU: begin
        op.valid     = 1'b1;
        op.a_sel     = A_GAIN;
        op.a_idx     = IDX_W'(ORDER);
        op.b_sel     = B_U;
        op.c_sel     = C_FWD;
        op.wb.step   = 1'b1;
        op.wb.dst    = D_DERIV;
        op.wb.d_idx  = IDX_W'(ORDER - 1);
        state_nxt    = S_GAPU;
      end
      // lets the last derivative land before the updates read it
      S_GAPU: begin
        state_nxt = S_UPD;
        cnt_nxt   = '0;
      end
      // x[r] += d[r]*dt
      S_UPD: begin
        op.valid     = 1'b1;
        op.a_sel     = A_DERIV;
        op.a_idx     = cnt_r;
        op.b_sel     = B_DT;
        op.c_sel     = C_STATE;
        op.c_idx     = cnt_r;
        op.wb.step   = 1'b1;
        op.wb.dst    = D_STATE;
        op.wb.d_idx  = cnt_r;
        if (cnt_r == IDX_W'(ORDER - 1)) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      // y = x[0] + g[0]*u, x[0] forwarded when it was updated just before
      S_OUT: begin
        op.valid     = 1'b1;
        op.a_sel     = A_GAIN;
        op.b_sel     = B_U;
        op.c_sel     = (ORDER == 1) ? C_FWD : C_STATE;
        op.wb.step   = 1'b1;
        op.wb.dst    = D_OUT;
        state_nxt    = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      // g[i] = b[i] - sum a[i-j+1]*g[j-1], j from i down to 1
      S_GROW: begin
        op.valid     = 1'b1;
        op.wb.dst    = D_GAIN;
        op.wb.d_idx  = gi_r;
        if (gi_r == '0) begin
          op.a_sel  = A_ZERO;
          op.b_sel  = B_U;
          op.c_sel  = C_NUM;
          op.c_idx  = '0;
          state_nxt = S_GGAP;
        end else begin
          op.a_sel = A_DEN;
          op.a_idx = gi_r - cnt_r;
          op.b_sel = B_GAIN;
          op.b_idx = cnt_r - IDX_W'(1);
          op.c_sel = (cnt_r == gi_r) ? C_NUM : C_FWD;
          op.c_idx = gi_r;
          op.sub   = 1'b1;
          if (cnt_r == IDX_W'(1)) begin
            state_nxt = S_GGAP;
          end else begin
            cnt_nxt = cnt_r - IDX_W'(1);
          end
        end
      end
      // gap so the finished gain is written before the next row
      S_GGAP: begin
        if (gi_r == IDX_W'(ORDER)) begin
          state_nxt = S_IDLE;
        end else begin
          gi_nxt    = gi_r + IDX_W'(1);
          cnt_nxt   = gi_r + IDX_W'(1);
          state_nxt = S_GROW;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a coefficient write takes the unit, no item is taken in that cycle
    if (derive_req) begin
      ctl.ready = 1'b0;
      state_nxt = S_GROW;
      gi_nxt    = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      gi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      gi_r    <= gi_nxt;
    end
  end

endmodule

FILE: hdl/euler_state_space_plant_step_top.sv
// top level of the forward euler state-space plant step
// uses esps_pkg, esps_seq and esps_mac
//
// Order-3 linear plant in controllable canonical form, stepped by forward
// euler in signed Q16.16 with every product and sum saturated to 32 bits.
// Each accepted item u advances the state once, x += (A*x + B*u)*dt, and
// returns y = x1 + beta0*u plus a flag that is set when any arithmetic of
// that step clipped. All arithmetic runs through one shared two-stage
// multiply/saturate/accumulate unit driven by a micro-op sequencer, one op
// per cycle outside its idle, gap, drain and output-wait states; in_stall
// is high from the acceptance of an item until the sequencer is idle
// again, so an item is finished before the next is taken. The result sits
// in an output register, so a result still waiting on out_stall does not
// block the work on the next item, only its delivery. Writing any
// coefficient register clears the state and rederives the gains beta on
// the same unit with the input stalled; writing time_step changes only dt.
module euler_state_space_plant_step_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [esps_pkg::DATA_W-1:0]     in_drive_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [esps_pkg::DATA_W-1:0]     out_plant_output,
  output logic                                   out_saturated,
  input  logic                                   cfg_wr_en,
  input  logic [esps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [esps_pkg::DATA_W-1:0]            cfg_wdata
);

  import esps_pkg::*;

  // configuration
  logic signed [DATA_W-1:0] den_r [DEN_N];
  logic signed [DATA_W-1:0] num_r [NUM_N];
  logic        [DT_W-1:0]   dt_r;

  // plant state, derivatives and gains
  logic signed [DATA_W-1:0] x_r [ORDER];
  logic signed [DATA_W-1:0] d_r [ORDER];
  logic signed [DATA_W-1:0] g_r [ORDER+1];

  logic signed [DATA_W-1:0] u_r;
  logic signed [DATA_W-1:0] y_r;
  logic                     sat_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_plant_output_r;
  logic                     out_saturated_r;

  op_t      op;
  seq_ctl_t ctl;
  logic     accept;
  logic     derive_req;
  logic     out_free;

  logic [IDX_W-1:0]         g_rd_idx;
  logic [IDX_W-1:0]         x_rd_idx;
  logic signed [DATA_W-1:0] g_rd;
  logic signed [DATA_W-1:0] x_rd;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] addend;

  logic                     res_valid;
  logic signed [DATA_W-1:0] res;
  logic                     res_sat;
  wb_t                      res_tag;

  assign accept     = in_valid && ctl.ready;
  assign in_stall   = !ctl.ready;
  // a coefficient write restarts the gain derivation from scratch
  assign derive_req = cfg_wr_en && (cfg_index != REG_DT);
  assign out_free   = !out_valid_r || !out_stall;

  esps_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .out_free   (out_free),
    .derive_req (derive_req),
    .op         (op),
    .ctl        (ctl)
  );

  // one read address per array and cycle
  always_comb begin
    g_rd_idx = (op.a_sel == A_GAIN) ? op.a_idx : op.b_idx;
    x_rd_idx = (op.b_sel == B_STATE) ? op.b_idx : op.c_idx;
    g_rd     = g_r[g_rd_idx];
    x_rd     = x_r[x_rd_idx];

    unique case (op.a_sel)
      A_ZERO:  mul_a = '0;
      A_DEN:   mul_a = den_r[CIDX_W'(op.a_idx)];
      A_GAIN:  mul_a = g_rd;
      A_DERIV: mul_a = d_r[op.a_idx];
      default: mul_a = '0;
    endcase

    unique case (op.b_sel)
      B_U:     mul_b = u_r;
      B_DT:    mul_b = DATA_W'(dt_r);
      B_STATE: mul_b = x_rd;
      B_GAIN:  mul_b = g_rd;
      default: mul_b = '0;
    endcase

    // a forwarded addend is picked up inside the unit
    unique case (op.c_sel)
      C_ZERO:  addend = '0;
      C_FWD:   addend = '0;
      C_STATE: addend = x_rd;
      C_NUM:   addend = num_r[CIDX_W'(op.c_idx)];
      default: addend = '0;
    endcase
  end

  esps_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .flush      (derive_req),
    .issue      (op.valid),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .addend     (addend),
    .addend_fwd (op.c_sel == C_FWD),
    .sub        (op.sub),
    .tag_in     (op.wb),
    .res_valid  (res_valid),
    .res        (res),
    .res_sat    (res_sat),
    .res_tag    (res_tag)
  );

  // configuration, state, gains and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEN_N; i++) begin
        den_r[i] <= '0;
      end
      for (int i = 0; i < NUM_N; i++) begin
        num_r[i] <= '0;
      end
      dt_r <= DT_RESET;
      for (int i = 0; i < ORDER; i++) begin
        x_r[i] <= '0;
      end
      // gains of the all-zero reset coefficients
      for (int i = 0; i <= ORDER; i++) begin
        g_r[i] <= '0;
      end
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_tag.dst == D_STATE) begin
        x_r[res_tag.d_idx] <= res;
      end
      if (res_valid && res_tag.dst == D_GAIN) begin
        g_r[res_tag.d_idx] <= res;
      end

      // saturation flag covers the step ops of the current item only
      if (accept) begin
        sat_r <= 1'b0;
      end else if (res_valid && res_tag.step && res_sat) begin
        sat_r <= 1'b1;
      end

      if (cfg_wr_en) begin
        priority if (cfg_index <= REG_DEN3) begin
          den_r[CIDX_W'(cfg_index - REG_DEN1)] <= cfg_wdata;
        end else if (cfg_index <= REG_NUM3) begin
          num_r[CIDX_W'(cfg_index - REG_NUM0)] <= cfg_wdata;
        end else begin
          dt_r <= cfg_wdata[DT_W-1:0];
        end
      end
      if (derive_req) begin
        for (int i = 0; i < ORDER; i++) begin
          x_r[i] <= '0;
        end
      end

      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      u_r <= in_drive_sample;
    end
    if (res_valid && res_tag.dst == D_DERIV) begin
      d_r[res_tag.d_idx] <= res;
    end
    if (res_valid && res_tag.dst == D_OUT) begin
      y_r <= res;
    end
    if (ctl.load_out) begin
      out_plant_output_r <= y_r;
      out_saturated_r    <= sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plant_output = out_plant_output_r;
  assign out_saturated    = out_saturated_r;

endmodule

FILE: hdl/esps_chk.sv
// port-level checker of the plant step block, bound to the top level
// uses the macros of euler_state_space_plant_step_top_assert.svh
`include "euler_state_space_plant_step_top_assert.svh"

module esps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_plant_output,
  input logic        out_saturated
);

  // a stalled result holds
  `ESPS_ASSERT(a_out_hold, rst_n && out_valid && out_stall |=> out_valid && $stable(out_plant_output) && $stable(out_saturated), "stalled result changed")

  // one item at a time: input closes right after an item is taken
  `ESPS_ASSERT(a_busy_after_accept, rst_n && in_valid && !in_stall |=> in_stall, "input open right after an accepted item")

  // a result only appears at the end of the work on an item
  `ESPS_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result appeared while idle")

  // reset empties the output register
  `ESPS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind euler_state_space_plant_step_top esps_chk u_esps_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_plant_output (out_plant_output),
  .out_saturated    (out_saturated)
);

FILE: dv/euler_state_space_plant_step_top_tb.sv
// testbench of the forward euler state-space plant step, order 3, signed q16.16
// needs esps_pkg and euler_state_space_plant_step_top; a local predictor checks every result
module euler_state_space_plant_step_top_tb;
  import esps_pkg::*;

  localparam int N              = ORDER;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRINT_CAP      = 100;
  localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;

  // register indexes as they appear on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    DEN_A1, DEN_A2, DEN_A3, NUM_B0, NUM_B1, NUM_B2, NUM_B3, STEP_DT
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     sat;
  } plant_out_t;

  typedef struct packed {
    reg_idx_e          idx;
    logic [DATA_W-1:0] data;
  } reg_write_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_drive_sample;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_plant_output;
  logic                     out_saturated;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;

  euler_state_space_plant_step_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_drive_sample  (in_drive_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plant_output (out_plant_output),
    .out_saturated    (out_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // predictor state: registers, derived gains, plant state
  // ---------------------------------------------------------------------
  int              den_c  [1:N];
  int              num_c  [0:N];
  int              gain_c [0:N];
  int              pstate [0:N-1];
  logic [DT_W-1:0] step_dt;
  bit              arith_sat;

  plant_out_t expected_outputs [$];
  reg_write_t pending_writes [$];

  // run bookkeeping
  int n_errors;
  int n_items;
  int n_results;
  int n_sat_results;
  int n_settings;

  // idling controls shared by the sender, the receiver and the tests
  bit send_gaps_on;
  bit recv_stalls_on;
  int hold_request;

  // ---------------------------------------------------------------------
  // q16.16 arithmetic with saturation tracking
  // ---------------------------------------------------------------------
  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) begin
      arith_sat = 1'b1;
      return int'(SAT_MAX);
    end
    if (v < -64'sd2147483648) begin
      arith_sat = 1'b1;
      return int'(SAT_MIN);
    end
    return int'(v);
  endfunction

  // exact product, floor shift by the fraction width, then clip
  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> FRAC_W);
  endfunction

  function automatic int qadd(int a, int b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(int a, int b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  // beta_i = b_i - sum a_{i-j+1}*beta_{j-1}, j from i down to 1; clears the plant
  function automatic void recompute_gains();
    int acc;
    int i, j;
    for (i = 0; i <= N; i++) gain_c[i] = 0;
    for (i = 0; i <= N; i++) begin
      acc = num_c[i];
      for (j = i; j >= 1; j--) acc = qsub(acc, qmul(den_c[i - j + 1], gain_c[j - 1]));
      gain_c[i] = acc;
    end
    for (i = 0; i < N; i++) pstate[i] = 0;
    // saturation here never shows up in a result
    arith_sat = 1'b0;
  endfunction

  function automatic void model_reset();
    int i;
    for (i = 1; i <= N; i++) den_c[i] = 0;
    for (i = 0; i <= N; i++) num_c[i] = 0;
    step_dt = DT_RESET;
    recompute_gains();
  endfunction

  function automatic void model_write(reg_idx_e idx, logic [DATA_W-1:0] data);
    if (idx == STEP_DT) begin
      // only dt changes, top bit dropped
      step_dt = data[DT_W-1:0];
    end else begin
      if (idx <= DEN_A3) den_c[int'(idx) + 1] = int'(data);
      else num_c[int'(idx) - int'(NUM_B0)] = int'(data);
      recompute_gains();
    end
  endfunction

  // one forward euler step, derivatives from the old state, output from the new one
  function automatic plant_out_t advance_plant(int u);
    int rate [0:N-1];
    int acc;
    int dt_q;
    int i;
    plant_out_t r;
    arith_sat = 1'b0;
    dt_q = int'({1'b0, step_dt});
    for (i = 0; i < N - 1; i++) rate[i] = qadd(pstate[i + 1], qmul(gain_c[i + 1], u));
    acc = 0;
    for (i = 0; i < N; i++) acc = qsub(acc, qmul(den_c[N - i], pstate[i]));
    rate[N - 1] = qadd(acc, qmul(gain_c[N], u));
    for (i = 0; i < N; i++) pstate[i] = qadd(pstate[i], qmul(rate[i], dt_q));
    r.y   = qadd(pstate[0], qmul(gain_c[0], u));
    r.sat = arith_sat;
    arith_sat = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // mismatch reporting, printing capped so a broken block stays readable
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("mismatch on %s at result %0d: got %h, want %h", what, n_results, got, want);
  endtask

  // ---------------------------------------------------------------------
  // result side: checks each accepted item, then decides the next stall
  // ---------------------------------------------------------------------
  task automatic check_plant_result();
    plant_out_t want;
    if (expected_outputs.size() == 0) begin
      report_mismatch("unexpected item", out_plant_output, '0);
    end else begin
      want = expected_outputs.pop_front();
      if (out_plant_output !== want.y) report_mismatch("plant_output", out_plant_output, want.y);
      if (out_saturated !== want.sat)
        report_mismatch("saturated", DATA_W'(out_saturated), DATA_W'(want.sat));
      if (want.sat) n_sat_results++;
    end
    n_results++;
  endtask

  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_plant_result();
      // a long hold-off asked by the pressure test, counted here
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: ends the run after too many cycles without any transfer
  // ---------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d items outstanding", quiet,
             expected_outputs.size());
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------
  // offers one sample, optionally after a gap, and predicts it once taken
  task automatic drive_sample(input logic signed [DATA_W-1:0] u);
    int gap;
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_drive_sample <= u;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_outputs.push_back(advance_plant(u));
    n_items++;
  endtask

  function automatic void stage_write(reg_idx_e idx, logic [DATA_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    pending_writes.push_back(w);
  endfunction

  // registers only change once the block has drained
  task automatic commit_writes();
    reg_write_t w;
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_wr_en <= 1'b1;
      cfg_index <= w.idx;
      cfg_wdata <= w.data;
      @(posedge clk);
      model_write(w.idx, w.data);
    end
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic program_plant(input logic [DATA_W-1:0] a1, a2, a3, b0, b1, b2, b3, dt);
    stage_write(DEN_A1, a1);
    stage_write(DEN_A2, a2);
    stage_write(DEN_A3, a3);
    stage_write(NUM_B0, b0);
    stage_write(NUM_B1, b1);
    stage_write(NUM_B2, b2);
    stage_write(NUM_B3, b3);
    stage_write(STEP_DT, dt);
    commit_writes();
  endtask

  // ---------------------------------------------------------------------
  // value pickers
  // ---------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return '0;
      3:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  // signed value within +-span
  function automatic logic [DATA_W-1:0] pick_near(int span);
    return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // mild samples keep a tame plant out of saturation for long runs
  function automatic logic [DATA_W-1:0] pick_sample(bit mild);
    int roll;
    roll = $urandom_range(0, 19);
    if (mild && roll < 18) return pick_near(4 * ONE);
    if (roll < 4) return pick_extreme();
    if (roll < 12) return $urandom;
    return pick_near(ONE);
  endfunction

  function automatic logic [DATA_W-1:0] pick_dt(bit mild);
    if (mild) return DATA_W'($urandom_range(0, ONE >>> 3));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom;
      default: return DATA_W'($urandom_range(0, ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // reset values: zero gains, so the output stays zero for any input
  task automatic test_reset_state();
    drive_sample(SAT_MAX);
    drive_sample(SAT_MIN);
    drive_sample('0);
    drive_sample(ONE);
  endtask

  // a plant with mixed-sign coefficients, driven with the input extremes;
  // the dt write carries a set top bit that has to be dropped
  task automatic test_input_extremes();
    program_plant(-ONE, '0, ONE >>> 2, ONE, 2 * ONE, -ONE, ONE >>> 1, 32'h8000_8000);
    drive_sample(SAT_MAX);
    drive_sample(SAT_MIN);
    drive_sample('0);
    drive_sample(32'sd1);
    drive_sample(-32'sd1);
    drive_sample(ONE);
  endtask

  // dt alone keeps state and gains: zero freezes the plant, full scale saturates
  task automatic test_time_step_extremes();
    stage_write(STEP_DT, '0);
    commit_writes();
    drive_sample(ONE);
    drive_sample(-ONE);
    stage_write(STEP_DT, {1'b0, {(DT_W){1'b1}}});
    commit_writes();
    drive_sample(ONE);
    drive_sample(SAT_MIN);
  endtask

  // rewriting one coefficient, even with its old value, clears the plant
  task automatic test_coeff_rewrite();
    stage_write(STEP_DT, ONE >>> 2);
    commit_writes();
    drive_sample(3 * ONE);
    stage_write(NUM_B2, -ONE);
    commit_writes();
    drive_sample(ONE);
    drive_sample(-2 * ONE);
  endtask

  // gain derivation saturates but must not flag a quiet step
  task automatic test_gain_saturation();
    program_plant(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, ONE);
    drive_sample('0);
    drive_sample(ONE);
    drive_sample(SAT_MIN);
  endtask

  // random settings, half tame plants that run deep, the rest wild, extreme or single-register rewrites
  task automatic test_random_plants(input int phases, input int per_phase);
    int p, k, style;
    bit mild;
    for (p = 0; p < phases; p++) begin
      style = $urandom_range(0, 9);
      mild  = (style < 5);
      if (mild)
        program_plant(pick_near(2 * ONE), pick_near(2 * ONE), pick_near(2 * ONE),
                      pick_near(ONE), pick_near(ONE), pick_near(ONE), pick_near(ONE),
                      pick_dt(1'b1));
      else if (style < 7)
        program_plant($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, pick_dt(1'b0));
      else if (style == 7)
        program_plant(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), pick_dt(1'b0));
      else if (style == 8) begin
        // dt only, the plant carries on from where it stood
        stage_write(STEP_DT, $urandom);
        commit_writes();
      end else begin
        stage_write(reg_idx_e'($urandom_range(int'(DEN_A1), int'(NUM_B3))), pick_near(ONE));
        commit_writes();
      end
      for (k = 0; k < per_phase; k++) drive_sample(pick_sample(mild));
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    int k;
    program_plant(pick_near(ONE), pick_near(ONE), pick_near(ONE), pick_near(ONE),
                  pick_near(ONE), pick_near(ONE), pick_near(ONE), pick_dt(1'b1));
    send_gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 40; k++) drive_sample(pick_sample(1'b1));
    send_gaps_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    int k;
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    program_plant(pick_near(2 * ONE), pick_near(2 * ONE), pick_near(2 * ONE), pick_near(ONE),
                  pick_near(ONE), pick_near(ONE), pick_near(ONE), pick_dt(1'b1));
    for (k = 0; k < 100; k++) drive_sample(pick_sample(k % 10 != 0));
  endtask

  // ---------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------
  initial begin
    in_valid        = 1'b0;
    in_drive_sample = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    send_gaps_on    = 1'b1;
    recv_stalls_on  = 1'b1;
    hold_request    = 0;
    n_errors        = 0;
    n_items         = 0;
    n_results       = 0;
    n_sat_results   = 0;
    n_settings      = 0;
    model_reset();

    // reset held from the start, released at an edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_input_extremes();
    test_time_step_extremes();
    test_coeff_rewrite();
    test_gain_saturation();
    test_random_plants(11, 50);
    test_output_backpressure();
    test_random_plants(11, 50);
    test_full_rate();

    // drain, then a short quiet tail for stray results
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_mismatch("missing item", '0, DATA_W'(expected_outputs.size()));

    $display("run covered %0d samples under %0d register settings", n_items, n_settings);
    $display("%0d results checked, %0d of them saturated, %0d mismatches", n_results,
             n_sat_results, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
